// File: rtl/julia_escape_time_iterator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julia escape-time iterator
// Shared property wrappers, all clocked on the rising edge of clock.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_ITERATOR_TOP_MACROS_SVH
`define JULIA_ESCAPE_TIME_ITERATOR_TOP_MACROS_SVH

// Property checked outside reset.
`define JET_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property that also covers the reset cycles.
`define JET_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Widths, formats, control records and sequencer states of the iterator.
// ----------------------------------------------------------------------------
package jet_pkg;

   localparam int FRAC_BITS = 29;
   localparam int IN_W      = 32;
   localparam int Z_W       = 40;             // Q10.29 working format
   localparam int HALF_W    = Z_W / 2;
   localparam int MAG_W     = 2 * Z_W;        // unsigned product magnitude
   localparam int PROD_W    = MAG_W + 1;      // signed product
   localparam int SUM_W     = PROD_W + 1;     // room for the update sums
   localparam int CNT_W     = 10;

   localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(100);
   // 4.0 at 2*FRAC_BITS fraction bits
   localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(1) << (2 * FRAC_BITS + 2);

   typedef logic signed [Z_W-1:0]    z_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   typedef struct packed {
      logic  start;
      z_type op_a;
      z_type op_b;
   } mul_req_type;

   typedef struct packed {
      logic     done;
      prod_type product;
   } mul_rsp_type;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] iter_count;
      logic             escaped;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE_RE,
      ST_WAIT_RE,
      ST_ISSUE_IM,
      ST_WAIT_IM,
      ST_CHECK,
      ST_ISSUE_RI,
      ST_WAIT_RI,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/jet_mul.sv
// ----------------------------------------------------------------------------
// jet_mul
// Shared signed multiplier: one half-width partial product per cycle,
// four passes per product, exact full-precision result.
// ----------------------------------------------------------------------------
module jet_mul import jet_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [Z_W-1:0]    mag_a_ff, mag_a_in;
   logic [Z_W-1:0]    mag_b_ff, mag_b_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  acc_ff, acc_in;
   logic [1:0]        step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [HALF_W-1:0] pp_a, pp_b;
   logic [2*HALF_W-1:0] pp;
   logic [MAG_W-1:0]  pp_shift;
   prod_type          prod_pos;

   function automatic logic [Z_W-1:0] magnitude(input logic [Z_W-1:0] v);
      return v[Z_W-1] ? (~v + Z_W'(1)) : v;
   endfunction

   always_comb begin
      // step bit 1 picks the upper half of a, bit 0 the upper half of b
      pp_a     = step_ff[1] ? mag_a_ff[Z_W-1 -: HALF_W] : mag_a_ff[HALF_W-1:0];
      pp_b     = step_ff[0] ? mag_b_ff[Z_W-1 -: HALF_W] : mag_b_ff[HALF_W-1:0];
      pp       = pp_a * pp_b;
      pp_shift = MAG_W'(pp) << (HALF_W * (step_ff[0] + step_ff[1]));

      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         mag_a_in = magnitude(mul_req.op_a);
         mag_b_in = magnitude(mul_req.op_b);
         neg_in   = mul_req.op_a[Z_W-1] ^ mul_req.op_b[Z_W-1];
         acc_in   = '0;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + pp_shift;
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      prod_pos        = {1'b0, acc_ff};
      mul_rsp.done    = done_ff;
      mul_rsp.product = neg_ff ? -prod_pos : prod_pos;
   end

endmodule

// File: rtl/jet_core.sv
// ----------------------------------------------------------------------------
// jet_core
// Sequencer and datapath: squares and cross product of z through the shared
// multiplier, escape test, update of z and iteration count.
// ----------------------------------------------------------------------------
module jet_core import jet_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [IN_W-1:0] start_re,
   input  logic signed [IN_W-1:0] start_im,
   input  logic signed [IN_W-1:0] const_re,
   input  logic signed [IN_W-1:0] const_im,
   input  logic [CNT_W-1:0]       max_iterations,
   output result_type             result,
   input  logic                   result_ready
);

   state_type        state_ff, state_in;
   z_type            re_ff, re_in, im_ff, im_in;
   z_type            cre_ff, cre_in, cim_ff, cim_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             first_ff, first_in;
   logic             esc_ff, esc_in;
   prod_type         sq_re_ff, sq_re_in, sq_im_ff, sq_im_in, prod_ff, prod_in;

   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;

   logic [SUM_W-1:0]        mag_sum;
   logic                    escape;
   logic signed [SUM_W-1:0] re_sum, im_sum;
   z_type                   re_next, im_next;

   jet_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      // squares are never negative
      mag_sum = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
      escape  = (mag_sum >= ESC_LIMIT);
      // fold c in before the shift so the slice gives the floored update
      re_sum  = SUM_W'(sq_re_ff) - SUM_W'(sq_im_ff) + (SUM_W'(cre_ff) <<< FRAC_BITS);
      im_sum  = (SUM_W'(prod_ff) <<< 1) + (SUM_W'(cim_ff) <<< FRAC_BITS);
      re_next = re_sum[FRAC_BITS +: Z_W];
      im_next = im_sum[FRAC_BITS +: Z_W];
   end

   always_comb begin
      state_in = state_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      cre_in   = cre_ff;
      cim_in   = cim_ff;
      limit_in = limit_ff;
      k_in     = k_ff;
      first_in = first_ff;
      esc_in   = esc_ff;
      sq_re_in = sq_re_ff;
      sq_im_in = sq_im_ff;
      prod_in  = prod_ff;

      mul_req.start = 1'b0;
      mul_req.op_a  = re_ff;
      mul_req.op_b  = re_ff;
      in_ready      = 1'b0;
      result.valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               re_in    = Z_W'(start_re);
               im_in    = Z_W'(start_im);
               cre_in   = Z_W'(const_re);
               cim_in   = Z_W'(const_im);
               limit_in = max_iterations;
               k_in     = '0;
               first_in = 1'b1;
               esc_in   = 1'b0;
               state_in = (max_iterations == '0) ? ST_DONE : ST_ISSUE_RE;
            end
         end
         ST_ISSUE_RE: begin
            mul_req.start = 1'b1;
            state_in      = ST_WAIT_RE;
         end
         ST_WAIT_RE: begin
            if (mul_rsp.done) begin
               sq_re_in = mul_rsp.product;
               state_in = ST_ISSUE_IM;
            end
         end
         ST_ISSUE_IM: begin
            mul_req.start = 1'b1;
            mul_req.op_a  = im_ff;
            mul_req.op_b  = im_ff;
            state_in      = ST_WAIT_IM;
         end
         ST_WAIT_IM: begin
            if (mul_rsp.done) begin
               sq_im_in = mul_rsp.product;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // the starting point itself is not tested
            if (first_ff) begin
               first_in = 1'b0;
               state_in = ST_ISSUE_RI;
            end else if (escape) begin
               esc_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = (k_ff + CNT_W'(1) == limit_ff) ? ST_DONE : ST_ISSUE_RI;
            end
         end
         ST_ISSUE_RI: begin
            mul_req.start = 1'b1;
            mul_req.op_b  = im_ff;
            state_in      = ST_WAIT_RI;
         end
         ST_WAIT_RI: begin
            if (mul_rsp.done) begin
               prod_in  = mul_rsp.product;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            re_in    = re_next;
            im_in    = im_next;
            state_in = ST_ISSUE_RE;
         end
         ST_DONE: begin
            result.valid = 1'b1;
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      result.iter_count = k_ff;
      result.escaped    = esc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      re_ff    <= re_in;
      im_ff    <= im_in;
      cre_ff   <= cre_in;
      cim_ff   <= cim_in;
      limit_ff <= limit_in;
      k_ff     <= k_in;
      first_ff <= first_in;
      esc_ff   <= esc_in;
      sq_re_ff <= sq_re_in;
      sq_im_ff <= sq_im_in;
      prod_ff  <= prod_in;
   end

endmodule

// File: rtl/julia_escape_time_iterator_top.sv
// ----------------------------------------------------------------------------
// julia_escape_time_iterator_top
// Julia-set escape-time iterator with a valid/stall request and result
// channel and a one-register write port for the iteration limit.
//
// Each request carries z0 and c in signed Q2.29. The block iterates
// z = z*z + c in Q10.29 with exact products and reports how many updates
// passed before |z|^2 reached 4, or the limit with escaped low. One item is
// worked on at a time and req_stall stays high until its result has moved
// to the output register. All products come from a single 20x20 multiplier
// that takes four passes per 40x40 product; one update of z needs three
// products plus a test and an update step. An item makes at most
// max_iterations updates (reset value 100), and a limit of zero sends the
// item to the result without any products.
// ----------------------------------------------------------------------------
module julia_escape_time_iterator_top import jet_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_start_re,
   input  logic signed [IN_W-1:0] req_start_im,
   input  logic signed [IN_W-1:0] req_const_re,
   input  logic signed [IN_W-1:0] req_const_im,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CNT_W-1:0]       rsp_iter_count,
   output logic                   rsp_escaped,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data
);

   logic [CNT_W-1:0] max_iter_ff, max_iter_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_escaped_ff, rsp_escaped_in;
   logic             core_ready;
   logic             result_ready;
   result_type       result;

   jet_core u_core (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (core_ready),
      .start_re       (req_start_re),
      .start_im       (req_start_im),
      .const_re       (req_const_re),
      .const_im       (req_const_im),
      .max_iterations (max_iter_ff),
      .result         (result),
      .result_ready   (result_ready)
   );

   always_comb begin
      max_iter_in = csr_wr_en ? csr_wr_data : max_iter_ff;

      // output register is free when empty or being drained this cycle
      result_ready   = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_escaped_in = rsp_escaped_ff;
      if (result.valid && result_ready) begin
         rsp_valid_in   = 1'b1;
         rsp_count_in   = result.iter_count;
         rsp_escaped_in = result.escaped;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= MAX_ITER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_iter_ff  <= max_iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff   <= rsp_count_in;
      rsp_escaped_ff <= rsp_escaped_in;
   end

   assign req_stall      = !core_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iter_count = rsp_count_ff;
   assign rsp_escaped    = rsp_escaped_ff;

endmodule

// File: rtl/jet_checker.sv
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks of the iterator, bound to the top level.
// ----------------------------------------------------------------------------
`include "julia_escape_time_iterator_top_macros.svh"

module jet_checker import jet_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [CNT_W-1:0]       rsp_iter_count,
   input logic                   rsp_escaped
);

   // a stalled result holds
   `JET_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_iter_count) && $stable(rsp_escaped), "result changed while stalled")

   // one item at a time: stall right after a request transfer
   `JET_ASSERT(a_busy_after_req, req_valid && !req_stall |=> req_stall, "request taken while busy")

   // no result can appear in the cycle after a request transfer
   `JET_ASSERT(a_no_instant_rsp, req_valid && !req_stall |=> !$rose(rsp_valid), "result appeared too early")

   // reset leaves the block empty and ready
   `JET_ASSERT_RST(a_reset_state, reset |=> !rsp_valid && !req_stall, "bad state after reset")

endmodule

bind julia_escape_time_iterator_top jet_checker u_checker (.*);
